/* rtl/core/pwnsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwnsr_pkg
// Shared types and constants for the pulse width nibble serial receiver.
// ----------------------------------------------------------------------------
package pwnsr_pkg;

  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned SYM_W     = 5;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // symbol windows: [SYM_BASE_US + SYM_STEP_US*i, +SYM_STEP_US], inclusive
  localparam int unsigned SYM_BASE_US = 996;
  localparam int unsigned SYM_STEP_US = 56;
  localparam int unsigned NUM_SYMS    = 18;

  localparam logic [SYM_W-1:0] SYM_REPEAT = 5'd16;
  localparam logic [SYM_W-1:0] SYM_IDLE   = 5'd17;
  localparam logic [SYM_W-1:0] SYM_NONE   = 5'd18;

  localparam logic [BYTE_W-1:0] RUN_MAX = 8'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ASYNCH_REPEATS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MSG_LEN    = 1'b1;

  localparam logic [BYTE_W-1:0] ASYNCH_RESET  = 8'd0;
  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd255;

  // one result item
  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic              char_done;
    logic [BYTE_W-1:0] char_value;
    logic              store_en;
    logic [BYTE_W-1:0] store_index;
    logic              idle_seen;
    logic              msg_end;
    logic [BYTE_W-1:0] msg_len;
    logic              msn_pending_end;
  } res_t;

  typedef struct packed {
    logic [BYTE_W-1:0] asynch_repeats;
    logic [BYTE_W-1:0] max_msg_len;
  } cfg_t;

endpackage

/* rtl/core/pwnsr_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwnsr_decode
// Maps a pulse width to a symbol; lowest matching window wins.
// ----------------------------------------------------------------------------
module pwnsr_decode
  import pwnsr_pkg::*;
(
  input  logic [WIDTH_W-1:0] width_i,
  output logic [SYM_W-1:0]   symbol_o
);

  logic [NUM_SYMS-1:0] hit;

  // independent window compares, one per symbol
  always_comb begin
    for (int i = 0; i < NUM_SYMS; i++) begin
      hit[i] = (width_i >= WIDTH_W'(SYM_BASE_US + SYM_STEP_US * i)) &&
               (width_i <= WIDTH_W'(SYM_BASE_US + SYM_STEP_US * (i + 1)));
    end
  end

  // priority pick, highest index first so the lowest overrides
  always_comb begin
    symbol_o = SYM_NONE;
    for (int i = NUM_SYMS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        symbol_o = SYM_W'(i);
      end
    end
  end

endmodule

/* rtl/core/pwnsr_assemble.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwnsr_assemble
// Run filter, nibble pairing and message counting; holds the frame state.
// ----------------------------------------------------------------------------
module pwnsr_assemble
  import pwnsr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  logic [SYM_W-1:0]  run_sym_q, run_sym_d;
  logic [BYTE_W-1:0] run_cnt_q, run_cnt_d;
  logic [SYM_W-1:0]  last_q, last_d;
  logic              low_q, low_d;
  logic              hp_q, hp_d;
  logic [BYTE_W-1:0] char_q, char_d;
  logic [BYTE_W-1:0] cnt_q, cnt_d;

  logic              sym_ok;
  logic [BYTE_W-1:0] cnt_base;
  logic [BYTE_W-1:0] run_next;
  logic              take;
  logic [SYM_W-1:0]  eff;
  logic              full;
  logic [BYTE_W-1:0] byte_val;

  always_comb begin
    sym_ok   = (symbol_i != SYM_NONE);
    cnt_base = (symbol_i != run_sym_q) ? '0 : run_cnt_q;
    run_next = (cnt_base == RUN_MAX) ? RUN_MAX : cnt_base + 8'd1;
    take     = sym_ok && ({1'b0, run_next} == ({1'b0, cfg_i.asynch_repeats} + 9'd1));
    eff      = (symbol_i == SYM_REPEAT) ? last_q : symbol_i;
    full     = (cnt_q >= cfg_i.max_msg_len);
    byte_val = {char_q[7:4], eff[3:0]};

    run_sym_d = run_sym_q;
    run_cnt_d = run_cnt_q;
    last_d    = last_q;
    low_d     = low_q;
    hp_d      = hp_q;
    char_d    = char_q;
    cnt_d     = cnt_q;

    res_o        = '0;
    res_o.symbol = symbol_i;

    if (sym_ok) begin
      run_sym_d = symbol_i;
      run_cnt_d = run_next;
    end

    if (take) begin
      last_d = eff;
      if (eff == SYM_IDLE) begin
        res_o.idle_seen = 1'b1;
        low_d           = 1'b0;
        if (hp_q) begin
          // unpaired high nibble closes the message, unless there is no room
          if (!full) begin
            res_o.store_en        = 1'b1;
            res_o.store_index     = cnt_q;
            res_o.char_value      = char_q;
            res_o.msg_end         = 1'b1;
            res_o.msg_len         = cnt_q;
            res_o.msn_pending_end = 1'b1;
          end
          cnt_d = '0;
          hp_d  = 1'b0;
        end else if (cnt_q != '0) begin
          res_o.msg_end = 1'b1;
          res_o.msg_len = cnt_q;
          cnt_d         = '0;
        end
      end else begin
        if (!low_q) begin
          char_d = {eff[3:0], 4'h0};
          hp_d   = 1'b1;
        end else begin
          char_d           = byte_val;
          hp_d             = 1'b0;
          res_o.char_done  = 1'b1;
          res_o.char_value = byte_val;
          if (!full) begin
            res_o.store_en    = 1'b1;
            res_o.store_index = cnt_q;
            cnt_d             = cnt_q + 8'd1;
          end else begin
            // buffer full: byte dropped, message closed
            if (cnt_q != '0) begin
              res_o.msg_end = 1'b1;
              res_o.msg_len = cnt_q;
            end
            cnt_d = '0;
          end
        end
        low_d = !low_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sym_q <= SYM_NONE;
      run_cnt_q <= '0;
      last_q    <= SYM_IDLE;
      low_q     <= 1'b0;
      hp_q      <= 1'b0;
      char_q    <= '0;
      cnt_q     <= '0;
    end else if (en_i) begin
      run_sym_q <= run_sym_d;
      run_cnt_q <= run_cnt_d;
      last_q    <= last_d;
      low_q     <= low_d;
      hp_q      <= hp_d;
      char_q    <= char_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

/* rtl/core/pulse_width_nibble_serial_receiver_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_nibble_serial_receiver_top
// Decodes one servo pulse width per item into a nibble symbol, filters runs,
// pairs nibbles into bytes and reports byte stores and message ends.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | pulse_width_us_i
//  out     | output    | out_valid_o/ out_stall_i| symbol_o .. msn_pending_end_o
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  A result passes through the input register, then through decode and
//  assembly into the result register. One item per cycle is sustained while
//  the output is not stalled; the limit is the update of the frame state as
//  an item leaves the input register.
//  Reset clears the handshake, frame state and configuration (asynch_repeats
//  0, max_msg_len 255). A stall on the output holds the result register and,
//  once the input register is also full, raises in_stall_o.
// ----------------------------------------------------------------------------
module pulse_width_nibble_serial_receiver_top
  import pwnsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WIDTH_W-1:0]   pulse_width_us_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SYM_W-1:0]     symbol_o,
  output logic                 char_done_o,
  output logic [BYTE_W-1:0]    char_value_o,
  output logic                 store_en_o,
  output logic [BYTE_W-1:0]    store_index_o,
  output logic                 idle_seen_o,
  output logic                 msg_end_o,
  output logic [BYTE_W-1:0]    msg_len_o,
  output logic                 msn_pending_end_o,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  // input register
  logic               s1_valid_q, s1_valid_d;
  logic [WIDTH_W-1:0] s1_width_q;
  // result register
  logic               out_valid_q, out_valid_d;
  res_t               out_q;
  // configuration
  cfg_t               cfg_q;

  logic               s1_move;
  logic               in_take;
  logic [SYM_W-1:0]   sym;
  res_t               res;

  // an item leaves the input register when the result register is free or
  // being emptied in the same cycle
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_width_q <= pulse_width_us_i;
    end
    if (s1_move) begin
      out_q <= res;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.asynch_repeats <= ASYNCH_RESET;
      cfg_q.max_msg_len    <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ASYNCH_REPEATS: cfg_q.asynch_repeats <= cfg_data_i;
        REG_MAX_MSG_LEN:    cfg_q.max_msg_len    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  pwnsr_decode u_decode (
    .width_i  (s1_width_q),
    .symbol_o (sym)
  );

  // frame state advances exactly when an item moves into the result register
  pwnsr_assemble u_assemble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s1_move),
    .symbol_i (sym),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  assign out_valid_o       = out_valid_q;
  assign symbol_o          = out_q.symbol;
  assign char_done_o       = out_q.char_done;
  assign char_value_o      = out_q.char_value;
  assign store_en_o        = out_q.store_en;
  assign store_index_o     = out_q.store_index;
  assign idle_seen_o       = out_q.idle_seen;
  assign msg_end_o         = out_q.msg_end;
  assign msg_len_o         = out_q.msg_len;
  assign msn_pending_end_o = out_q.msn_pending_end;

  // a held input item is never lost while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> s1_valid_q)
    else $error("input item dropped while stalled");

  // a dangling high nibble is only reported as a stored, closing idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.msn_pending_end) |->
      (out_q.idle_seen && out_q.store_en && out_q.msg_end))
    else $error("pending nibble end without idle store");

  // idle and a completed byte are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.char_done) |-> !out_q.idle_seen)
    else $error("byte completed on idle");

  // an out-of-range frame causes no action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.symbol == SYM_NONE)) |->
      (!out_q.char_done && !out_q.idle_seen && !out_q.store_en && !out_q.msg_end))
    else $error("action on out-of-range frame");

endmodule
